/* rtl/spbm_pkg.sv */
// ----------------------------------------------------------------------------
// spbm_pkg
// Shared types and constants of the sparse paged byte memory.
// ----------------------------------------------------------------------------
package spbm_pkg;
	localparam int PageBytes = 256;
	localparam int MaxPages  = 64;
	localparam int OffW      = $clog2(PageBytes);
	localparam int SlotW     = $clog2(MaxPages);
	localparam int TagW      = 32 - OffW;
	localparam int CntW      = SlotW + 1;
	localparam int ByteAw    = SlotW + OffW;
	localparam int ByteDepth = MaxPages * PageBytes;
	localparam int DirW      = TagW + SlotW;

	localparam logic [1:0] ModeWrite  = 2'd0;
	localparam logic [1:0] ModeRead   = 2'd1;
	localparam logic [1:0] ModeProbe  = 2'd2;
	localparam logic [1:0] ModeUnused = 2'd3;

	localparam logic [2:0] StOk        = 3'd0;
	localparam logic [2:0] StRedundant = 3'd1;
	localparam logic [2:0] StOverwrite = 3'd2;
	localparam logic [2:0] StDropped   = 3'd3;
	localparam logic [2:0] StFull      = 3'd4;

	localparam logic RegCheckDup  = 1'b0;
	localparam logic RegAllowOver = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SEARCH,
		S_SRCH_WAIT,
		S_SRCH_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_INSERT,
		S_BYTE_RD,
		S_BYTE_WAIT,
		S_BYTE_DONE
	} state_t;
endpackage

/* rtl/spbm_ram.sv */
// ----------------------------------------------------------------------------
// spbm_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module spbm_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* rtl/sparse_paged_byte_memory_unit.sv */
// ----------------------------------------------------------------------------
// sparse_paged_byte_memory_unit
// Sparse byte memory: recent-page check, binary search over a sorted page
// directory with ordered insertion, and a byte store with set marks.
// ----------------------------------------------------------------------------
//  channel   | handshake             | payload
//  ----------+-----------------------+--------------------------------------
//  command   | start / busy          | mode, address, write_data
//  result    | done (one cycle)      | read_data, was_set, status
//  config    | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  A recent-page hit goes to the byte read; unused mode ends in search. Each
//  directory probe (up to 7) reads an entry, waits for the RAM and compares; a
//  hit reads the byte, a read miss or full table ends the search, and an insertion
//  moves each later entry up a slot (a read and a write each) through the single
//  directory RAM port. After reset a clearing pass over every byte entry wipes
//  the set marks; busy stays high. The receiver cannot stall; done lasts one cycle.
module sparse_paged_byte_memory_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] address,
	input  logic [7:0]  write_data,
	output logic        done,
	output logic [7:0]  read_data,
	output logic        was_set,
	output logic [2:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic        cfg_data
);
	spbm_pkg::state_t state_q, state_d;

	logic                          chk_dup_q, allow_ow_q;
	logic [1:0]                    mode_q;
	logic [spbm_pkg::TagW-1:0]     tag_q;
	logic [spbm_pkg::OffW-1:0]     off_q;
	logic [7:0]                    wdata_q;
	logic [spbm_pkg::CntW-1:0]     count_q;
	logic                          rec_valid_q;
	logic [spbm_pkg::TagW-1:0]     rec_tag_q;
	logic [spbm_pkg::SlotW-1:0]    rec_slot_q;
	logic [spbm_pkg::CntW-1:0]     lo_q, hi_q, k_q;
	logic [spbm_pkg::SlotW-1:0]    slot_q;
	logic [spbm_pkg::DirW-1:0]     shift_q;
	logic [spbm_pkg::ByteAw-1:0]   clr_q;

	// directory ram
	logic                          dir_we;
	logic [spbm_pkg::SlotW-1:0]    dir_addr;
	logic [spbm_pkg::DirW-1:0]     dir_wdata, dir_rdata;
	// byte ram: {valid, data}
	logic                          byte_we;
	logic [spbm_pkg::ByteAw-1:0]   byte_addr;
	logic [8:0]                    byte_wdata, byte_rdata;

	spbm_ram #(.Width(spbm_pkg::DirW), .Depth(spbm_pkg::MaxPages)) u_dir (
		.clk(clk), .we(dir_we), .addr(dir_addr), .wdata(dir_wdata), .rdata(dir_rdata)
	);
	spbm_ram #(.Width(9), .Depth(spbm_pkg::ByteDepth)) u_byte (
		.clk(clk), .we(byte_we), .addr(byte_addr), .wdata(byte_wdata),
		.rdata(byte_rdata)
	);

	logic [spbm_pkg::CntW-1:0]  mid;
	logic [spbm_pkg::TagW-1:0]  dir_tag;
	logic [spbm_pkg::SlotW-1:0] dir_slot;
	logic                       hit_rec;
	logic                       old_set;
	logic [7:0]                 old_data;
	logic                       store_en;
	logic [2:0]                 wr_status;

	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign dir_tag  = dir_rdata[spbm_pkg::DirW-1:spbm_pkg::SlotW];
	assign dir_slot = dir_rdata[spbm_pkg::SlotW-1:0];
	assign hit_rec  = rec_valid_q && (rec_tag_q == tag_q);
	assign old_set  = byte_rdata[8];
	assign old_data = byte_rdata[7:0];

	always_comb begin
		store_en  = 1'b1;
		wr_status = spbm_pkg::StOk;
		if (chk_dup_q && old_set) begin
			if (wdata_q == old_data) begin
				wr_status = spbm_pkg::StRedundant;
			end else if (allow_ow_q) begin
				wr_status = spbm_pkg::StOverwrite;
			end else begin
				wr_status = spbm_pkg::StDropped;
				store_en  = 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spbm_pkg::S_CLEAR: begin
				if (clr_q == spbm_pkg::ByteAw'(spbm_pkg::ByteDepth - 1)) begin
					state_d = spbm_pkg::S_IDLE;
				end
			end
			spbm_pkg::S_IDLE: begin
				if (start) begin
					state_d = spbm_pkg::S_SEARCH;
				end
			end
			spbm_pkg::S_SEARCH: begin
				if (mode_q == spbm_pkg::ModeUnused) begin
					state_d = spbm_pkg::S_IDLE;
				end else if (hit_rec) begin
					state_d = spbm_pkg::S_BYTE_RD;
				end else if (lo_q < hi_q) begin
					state_d = spbm_pkg::S_SRCH_WAIT;
				end else if (mode_q != spbm_pkg::ModeWrite) begin
					state_d = spbm_pkg::S_IDLE;
				end else if (count_q >= spbm_pkg::CntW'(spbm_pkg::MaxPages)) begin
					state_d = spbm_pkg::S_IDLE;
				end else if (k_q > lo_q) begin
					state_d = spbm_pkg::S_SHIFT_RD;
				end else begin
					state_d = spbm_pkg::S_INSERT;
				end
			end
			spbm_pkg::S_SRCH_WAIT: state_d = spbm_pkg::S_SRCH_CMP;
			spbm_pkg::S_SRCH_CMP: begin
				if (dir_tag == tag_q) begin
					state_d = spbm_pkg::S_BYTE_RD;
				end else begin
					state_d = spbm_pkg::S_SEARCH;
				end
			end
			spbm_pkg::S_SHIFT_RD: state_d = spbm_pkg::S_SHIFT_WR;
			spbm_pkg::S_SHIFT_WR: begin
				if (k_q - 1'b1 > lo_q) begin
					state_d = spbm_pkg::S_SHIFT_RD;
				end else begin
					state_d = spbm_pkg::S_INSERT;
				end
			end
			spbm_pkg::S_INSERT:    state_d = spbm_pkg::S_BYTE_RD;
			spbm_pkg::S_BYTE_RD:   state_d = spbm_pkg::S_BYTE_WAIT;
			spbm_pkg::S_BYTE_WAIT: state_d = spbm_pkg::S_BYTE_DONE;
			spbm_pkg::S_BYTE_DONE: state_d = spbm_pkg::S_IDLE;
			default:               state_d = spbm_pkg::S_IDLE;
		endcase
	end

	// memory controls and outputs
	always_comb begin
		dir_we     = 1'b0;
		dir_addr   = mid[spbm_pkg::SlotW-1:0];
		dir_wdata  = shift_q;
		byte_we    = 1'b0;
		byte_addr  = {slot_q, off_q};
		byte_wdata = {1'b1, wdata_q};
		done       = 1'b0;
		read_data  = 8'd0;
		was_set    = 1'b0;
		status     = spbm_pkg::StOk;
		busy       = (state_q != spbm_pkg::S_IDLE);
		cfg_ready  = (state_q == spbm_pkg::S_IDLE) || (state_q == spbm_pkg::S_CLEAR);
		unique case (state_q)
			spbm_pkg::S_CLEAR: begin
				byte_we    = 1'b1;
				byte_addr  = clr_q;
				byte_wdata = 9'd0;
			end
			spbm_pkg::S_SEARCH: begin
				if (mode_q == spbm_pkg::ModeUnused) begin
					done = 1'b1;
				end else if (!hit_rec && !(lo_q < hi_q)) begin
					if (mode_q != spbm_pkg::ModeWrite) begin
						done = 1'b1;
					end else if (count_q >= spbm_pkg::CntW'(spbm_pkg::MaxPages)) begin
						done   = 1'b1;
						status = spbm_pkg::StFull;
					end
				end
			end
			spbm_pkg::S_SHIFT_RD: begin
				dir_addr = spbm_pkg::SlotW'(k_q - 1'b1);
			end
			spbm_pkg::S_SHIFT_WR: begin
				dir_we    = 1'b1;
				dir_addr  = k_q[spbm_pkg::SlotW-1:0];
				dir_wdata = dir_rdata;
			end
			spbm_pkg::S_INSERT: begin
				dir_we    = 1'b1;
				dir_addr  = lo_q[spbm_pkg::SlotW-1:0];
				dir_wdata = {tag_q, count_q[spbm_pkg::SlotW-1:0]};
			end
			spbm_pkg::S_BYTE_DONE: begin
				done      = 1'b1;
				read_data = old_set ? old_data : 8'd0;
				was_set   = old_set;
				if (mode_q == spbm_pkg::ModeWrite) begin
					status  = wr_status;
					byte_we = store_en;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spbm_pkg::S_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			rec_valid_q <= 1'b0;
			chk_dup_q   <= 1'b0;
			allow_ow_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == spbm_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == spbm_pkg::RegCheckDup) begin
					chk_dup_q <= cfg_data;
				end else begin
					allow_ow_q <= cfg_data;
				end
			end
			if (state_q == spbm_pkg::S_SRCH_CMP && dir_tag == tag_q) begin
				rec_valid_q <= 1'b1;
			end
			if (state_q == spbm_pkg::S_INSERT) begin
				rec_valid_q <= 1'b1;
				count_q     <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == spbm_pkg::S_IDLE && start) begin
			mode_q  <= mode;
			tag_q   <= address[31:spbm_pkg::OffW];
			off_q   <= address[spbm_pkg::OffW-1:0];
			wdata_q <= write_data;
			lo_q    <= '0;
			hi_q    <= count_q;
			k_q     <= count_q;
		end
		if (state_q == spbm_pkg::S_SEARCH && hit_rec) begin
			slot_q <= rec_slot_q;
		end
		if (state_q == spbm_pkg::S_SRCH_CMP) begin
			if (dir_tag == tag_q) begin
				slot_q     <= dir_slot;
				rec_tag_q  <= tag_q;
				rec_slot_q <= dir_slot;
			end else if (tag_q < dir_tag) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid + 1'b1;
			end
		end
		if (state_q == spbm_pkg::S_SHIFT_WR) begin
			k_q <= k_q - 1'b1;
		end
		if (state_q == spbm_pkg::S_INSERT) begin
			slot_q     <= count_q[spbm_pkg::SlotW-1:0];
			rec_tag_q  <= tag_q;
			rec_slot_q <= count_q[spbm_pkg::SlotW-1:0];
		end
		shift_q <= dir_rdata;
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> state_q == spbm_pkg::S_IDLE) else $error("done not followed by idle");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= spbm_pkg::CntW'(spbm_pkg::MaxPages)) else $error("page count overflow");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> $past(state_q) == spbm_pkg::S_INSERT)
		else $error("page count changed outside insert");
	a_full_write: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == spbm_pkg::StFull |-> mode_q == spbm_pkg::ModeWrite)
		else $error("table full on non-write");
endmodule
